@@ hw/rtl/seconds_to_civil_datetime_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the timestamp-to-calendar block
// Concurrent check helpers clocked on clk and held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SECONDS_TO_CIVIL_DATETIME_DEFINES_SVH
`define SECONDS_TO_CIVIL_DATETIME_DEFINES_SVH

// Check that cons holds in the same cycle as ante
`define SCDT_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("check failed: implication");

// Check that cons holds a fixed number of cycles after ante
`define SCDT_ASSERT_DELAY(lbl, ante, cons, dly) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##dly (cons)) \
		else $error("check failed: delayed implication");

`endif

@@ hw/rtl/scdt_pkg.sv @@
// ----------------------------------------------------------------------------
// scdt_pkg
// Constants and tables for the seconds-to-calendar conversion pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package scdt_pkg;

	// Widths of the ports
	localparam int OFFSET_W = 34;
	localparam int BOOT_W   = 32;
	localparam int UNIX_W   = 35;

	// Unix seconds at 1901-01-01 00:00 and at 2243-01-01 00:00
	localparam logic signed [UNIX_W-1:0] UNIX_MIN = -35'sd2177452800;
	localparam logic signed [UNIX_W-1:0] UNIX_END = 35'sd8615030400;

	// Floor division by 86400: shift by 7, then reciprocal of 675 with shift 37
	localparam logic [27:0] DAY_RECIP    = 28'd203613265;
	localparam logic [16:0] SECS_PER_DAY = 17'd86400;

	// Day count from 1901-01-01 where the 400-year era starting in 2000 begins
	localparam logic [16:0] ERA5_DAY    = 17'd36219;
	localparam logic [17:0] ERA5_SHIFT  = 18'd36219;
	localparam logic [17:0] ERA4_SHIFT  = 18'd109878;

	// Day-of-era breakpoints
	localparam logic [17:0] DOE_CENT1   = 18'd36524;
	localparam logic [17:0] DOE_CENT2   = 18'd73048;
	localparam logic [17:0] DOE_CENT3   = 18'd109572;
	localparam logic [17:0] DOE_LAST    = 18'd146096;

	// Reciprocals: /1460 as (x>>2)/365 shift 25, /365 shift 27
	localparam logic [16:0] Q1460_RECIP = 17'd91930;
	localparam logic [18:0] YEAR_RECIP  = 19'd367720;
	localparam logic [17:0] DAYS_PER_YR = 18'd365;

	// Month index: (5*doy+2)/153 with reciprocal 3427, shift 19
	localparam logic [11:0] MP_RECIP    = 12'd3427;

	// Time of day: /60 as (x>>2)/15 shift 19, hour as (x>>2)/15 shift 13
	localparam logic [15:0] MIN_RECIP   = 16'd34953;
	localparam logic [9:0]  HOUR_RECIP  = 10'd547;

	// Era base years
	localparam logic [11:0] ERA4_YEAR   = 12'd1600;
	localparam logic [11:0] ERA5_YEAR   = 12'd2000;

	// Saturation values
	localparam logic [11:0] YEAR_LO = 12'd1901;
	localparam logic [11:0] YEAR_HI = 12'd2242;

	// Pipeline depth from request to result strobe
	localparam int LATENCY = 14;

	// First day of year (March-based) of each month index
	function automatic logic [8:0] month_start(input logic [3:0] mp);
		logic [8:0] r;
		unique case (mp)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

@@ hw/rtl/seconds_to_civil_datetime.sv @@
// ----------------------------------------------------------------------------
// seconds_to_civil_datetime
// Converts a boot-relative seconds count plus a signed epoch offset into a
// Gregorian year, month, day, hour and minute, clipped to 1901..2242.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle; busy stays low.
// Reset: arst_n clears the stage valid bits and the epoch offset to zero;
//   results come out in request order and the receiver cannot stall them.
`timescale 1ns / 1ps
`include "seconds_to_civil_datetime_defines.svh"

module seconds_to_civil_datetime
	import scdt_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic signed [OFFSET_W-1:0] epoch_offset_seconds,
	input  logic                       start,
	output logic                       busy,
	input  logic [BOOT_W-1:0]          boot_seconds,
	output logic                       done,
	output logic [11:0]                year,
	output logic [3:0]                 month,
	output logic [4:0]                 day_of_month,
	output logic [4:0]                 hour,
	output logic [5:0]                 minute
);

	// Offset register and stage valid bits
	logic signed [OFFSET_W-1:0] offset_q;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic v_s8, v_s9, v_s10, v_s11, v_s12, v_s13, v_s14;

	// Range and saturation flags
	logic signed [UNIX_W-1:0] unix_s1;
	logic signed [UNIX_W-1:0] u_sum;
	logic lo_s2, lo_s3, lo_s4, lo_s5, lo_s6, lo_s7, lo_s8;
	logic lo_s9, lo_s10, lo_s11, lo_s12, lo_s13;
	logic hi_s2, hi_s3, hi_s4, hi_s5, hi_s6, hi_s7, hi_s8;
	logic hi_s9, hi_s10, hi_s11, hi_s12, hi_s13;

	// Day split
	logic [33:0] u_s2;
	logic [54:0] dprod_s3;
	logic [16:0] u_s3;
	logic [16:0] days;
	logic [16:0] days_s4;
	logic [16:0] sod_s4;

	// Date path
	logic era_s5, era_s6, era_s7, era_s8, era_s9, era_s10, era_s11, era_s12, era_s13;
	logic [17:0] doe_s5, doe_s6, doe_s7, doe_s8, doe_s9;
	logic [32:0] q1460prod_s6;
	logic [2:0]  cent;
	logic [2:0]  cent_s6;
	logic        top_s6;
	logic [17:0] t_s7;
	logic [35:0] yprod_s8;
	logic [8:0]  yoe_s9, yoe_s10, yoe_s11, yoe_s12, yoe_s13;
	logic [1:0]  c100;
	logic [8:0]  doy_s10, doy_s11, doy_s12, doy_s13;
	logic [10:0] num_s11;
	logic [22:0] mprod_s12;
	logic [3:0]  mp_s13;

	// Time path
	logic [30:0] mprod_s5;
	logic [10:0] mod_s6, mod_s7, mod_s8;
	logic [17:0] hprod_s7;
	logic [4:0]  hour_s8, hour_s9, hour_s10, hour_s11, hour_s12, hour_s13;
	logic [5:0]  minute_s9, minute_s10, minute_s11, minute_s12, minute_s13;

	// Final assembly
	logic [3:0]  month_c;
	logic [11:0] year_c;
	logic [4:0]  day_c;

	// Always ready on both request channels
	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	// Hold the epoch offset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			offset_q <= epoch_offset_seconds;
		end
	end

	// Advance the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
			v_s14 <= 1'b0;
		end else begin
			v_s1  <= start && !busy;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
			v_s14 <= v_s13;
		end
	end

	// Combinational helpers between stages
	assign u_sum = unix_s1 - UNIX_MIN;
	assign days  = dprod_s3[53:37];
	assign cent  = 3'(doe_s5 >= DOE_CENT1) + 3'(doe_s5 >= DOE_CENT2)
		+ 3'(doe_s5 >= DOE_CENT3) + 3'(doe_s5 >= DOE_LAST);
	assign c100  = 2'(yoe_s9 >= 9'd100) + 2'(yoe_s9 >= 9'd200) + 2'(yoe_s9 >= 9'd300);

	// Stages 1 to 5: Unix seconds, range check, day count, second of day, era, minute product
	always_ff @(posedge clk) begin
		unix_s1  <= $signed({3'b000, boot_seconds}) + $signed({offset_q[OFFSET_W-1], offset_q});

		lo_s2    <= unix_s1 < UNIX_MIN;
		hi_s2    <= unix_s1 >= UNIX_END;
		u_s2     <= u_sum[33:0];

		dprod_s3 <= 55'(u_s2[33:7]) * 55'(DAY_RECIP);
		u_s3     <= u_s2[16:0];
		lo_s3    <= lo_s2;
		hi_s3    <= hi_s2;

		days_s4  <= days;
		sod_s4   <= u_s3 - days * SECS_PER_DAY;
		lo_s4    <= lo_s3;
		hi_s4    <= hi_s3;

		era_s5   <= days_s4 >= ERA5_DAY;
		doe_s5   <= (days_s4 >= ERA5_DAY) ? 18'(days_s4) - ERA5_SHIFT
			: 18'(days_s4) + ERA4_SHIFT;
		mprod_s5 <= 31'(sod_s4[16:2]) * 31'(MIN_RECIP);
		lo_s5    <= lo_s4;
		hi_s5    <= hi_s4;
	end

	// Stages 6 to 9: year of era and time of day
	always_ff @(posedge clk) begin
		q1460prod_s6 <= 33'(doe_s5[17:2]) * 33'(Q1460_RECIP);
		cent_s6      <= cent;
		top_s6       <= doe_s5 == DOE_LAST;
		doe_s6       <= doe_s5;
		mod_s6       <= mprod_s5[29:19];
		era_s6       <= era_s5;
		lo_s6        <= lo_s5;
		hi_s6        <= hi_s5;

		t_s7         <= doe_s6 - 18'(q1460prod_s6[31:25]) + 18'(cent_s6) - 18'(top_s6);
		hprod_s7     <= 18'(mod_s6[10:2]) * 18'(HOUR_RECIP);
		mod_s7       <= mod_s6;
		doe_s7       <= doe_s6;
		era_s7       <= era_s6;
		lo_s7        <= lo_s6;
		hi_s7        <= hi_s6;

		yprod_s8     <= 36'(t_s7) * 36'(YEAR_RECIP);
		hour_s8      <= hprod_s7[17:13];
		mod_s8       <= mod_s7;
		doe_s8       <= doe_s7;
		era_s8       <= era_s7;
		lo_s8        <= lo_s7;
		hi_s8        <= hi_s7;

		yoe_s9       <= yprod_s8[35:27];
		minute_s9    <= 6'(mod_s8 - 11'(hour_s8) * 11'd60);
		hour_s9      <= hour_s8;
		doe_s9       <= doe_s8;
		era_s9       <= era_s8;
		lo_s9        <= lo_s8;
		hi_s9        <= hi_s8;
	end

	// Stages 10 to 13: day of year and month index
	always_ff @(posedge clk) begin
		doy_s10    <= 9'(doe_s9 - (18'(yoe_s9) * DAYS_PER_YR + 18'(yoe_s9[8:2]) - 18'(c100)));
		yoe_s10    <= yoe_s9;
		era_s10    <= era_s9;
		hour_s10   <= hour_s9;
		minute_s10 <= minute_s9;
		lo_s10     <= lo_s9;
		hi_s10     <= hi_s9;

		num_s11    <= {doy_s10, 2'b00} + 11'(doy_s10) + 11'd2;
		doy_s11    <= doy_s10;
		yoe_s11    <= yoe_s10;
		era_s11    <= era_s10;
		hour_s11   <= hour_s10;
		minute_s11 <= minute_s10;
		lo_s11     <= lo_s10;
		hi_s11     <= hi_s10;

		mprod_s12  <= 23'(num_s11) * 23'(MP_RECIP);
		doy_s12    <= doy_s11;
		yoe_s12    <= yoe_s11;
		era_s12    <= era_s11;
		hour_s12   <= hour_s11;
		minute_s12 <= minute_s11;
		lo_s12     <= lo_s11;
		hi_s12     <= hi_s11;

		mp_s13     <= mprod_s12[22:19];
		doy_s13    <= doy_s12;
		yoe_s13    <= yoe_s12;
		era_s13    <= era_s12;
		hour_s13   <= hour_s12;
		minute_s13 <= minute_s12;
		lo_s13     <= lo_s12;
		hi_s13     <= hi_s12;
	end

	// Map the March-based month index to the calendar, finish the year and the day of month
	always_comb begin
		month_c = (mp_s13 < 4'd10) ? mp_s13 + 4'd3 : mp_s13 - 4'd9;
		year_c  = 12'(yoe_s13) + (era_s13 ? ERA5_YEAR : ERA4_YEAR) + 12'(mp_s13 >= 4'd10);
		day_c   = 5'(doy_s13 - month_start(mp_s13) + 9'd1);
	end

	// Stage 14: saturate and drive the result
	always_ff @(posedge clk) begin
		priority if (lo_s13) begin
			year         <= YEAR_LO;
			month        <= 4'd1;
			day_of_month <= 5'd1;
			hour         <= 5'd0;
			minute       <= 6'd0;
		end else if (hi_s13) begin
			year         <= YEAR_HI;
			month        <= 4'd12;
			day_of_month <= 5'd31;
			hour         <= 5'd23;
			minute       <= 6'd59;
		end else begin
			year         <= year_c;
			month        <= month_c;
			day_of_month <= day_c;
			hour         <= hour_s13;
			minute       <= minute_s13;
		end
	end

	assign done = v_s14;

	// Checks
	`SCDT_ASSERT_DELAY(a_req_to_done, start && !busy, done, LATENCY)
	`SCDT_ASSERT_IMPL(a_done_has_req, done, $past(start && !busy, LATENCY))
	`SCDT_ASSERT_IMPL(a_date_legal, done, (month >= 4'd1) && (month <= 4'd12) && (day_of_month != 5'd0))
	`SCDT_ASSERT_IMPL(a_time_legal, done, (hour <= 5'd23) && (minute <= 6'd59))
	`SCDT_ASSERT_IMPL(a_year_range, done, (year >= YEAR_LO) && (year <= YEAR_HI))
	`SCDT_ASSERT_IMPL(a_feb_short, done && (month == 4'd2), day_of_month <= 5'd29)

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: timestamp-to-calendar converter testbench
// Sends boot-relative seconds counts under a range of epoch offsets and checks
// every year, month, day, hour and minute against an in-bench calendar
// predictor. Covers leap days, century years, negative Unix time and the
// clipping at both ends of the year range, then random traffic with and without idle gaps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

	localparam longint DAY_SECS    = 86400;
	localparam longint HOUR_SECS   = 3600;
	localparam longint MIN_SECS    = 60;
	localparam longint DAY_BIAS    = 719468;
	localparam longint ERA_DAYS    = 146097;
	localparam longint YEAR_FIRST  = 1901;
	localparam longint YEAR_LAST   = 2242;
	localparam longint UNIX_FIRST  = -64'sd2177452800;
	localparam longint UNIX_BEYOND = 64'sd8615030400;
	localparam longint OFS_MIN     = -64'sd8589934592;
	localparam longint OFS_MAX     = 64'sd8589934591;
	localparam longint OFS_LOW     = -64'sd2147483648;
	localparam int     DRAIN_WAIT  = scdt_pkg::LATENCY + 4;
	localparam int     CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
	} civil_t;

	logic                                clk = 1'b0;
	logic                                arst_n;
	logic                                cfg_valid;
	logic                                cfg_ready;
	logic signed [scdt_pkg::OFFSET_W-1:0] epoch_offset_seconds;
	logic                                start;
	logic                                busy;
	logic [scdt_pkg::BOOT_W-1:0]         boot_seconds;
	logic                                done;
	logic [11:0]                         year;
	logic [3:0]                          month;
	logic [4:0]                          day_of_month;
	logic [4:0]                          hour;
	logic [5:0]                          minute;

	civil_t            expected_dates[$];
	logic signed [33:0] offset_now = '0;
	int                errors = 0;
	int                sent = 0;
	int                checked = 0;
	int                offset_writes = 0;
	int                cycle_count = 0;

	seconds_to_civil_datetime u_top (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cfg_valid            (cfg_valid),
		.cfg_ready            (cfg_ready),
		.epoch_offset_seconds (epoch_offset_seconds),
		.start                (start),
		.busy                 (busy),
		.boot_seconds         (boot_seconds),
		.done                 (done),
		.year                 (year),
		.month                (month),
		.day_of_month         (day_of_month),
		.hour                 (hour),
		.minute               (minute)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d dates outstanding", $time, expected_dates.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	// Division rounding toward minus infinity, positive divisor
	function automatic longint floor_quot(input longint a, input longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && a < 0)
			q -= 1;
		return q;
	endfunction

	// Calendar predictor: boot seconds plus offset to a clipped civil date
	function automatic civil_t to_civil(input logic [31:0] secs, input logic signed [33:0] offset);
		longint unix_s, days, sod, z, era, doe, yoe, doy, mp, d, m, y;
		civil_t r;
		unix_s = longint'(secs) + longint'(offset);
		days   = floor_quot(unix_s, DAY_SECS);
		sod    = unix_s - days * DAY_SECS;
		z      = days + DAY_BIAS;
		era    = floor_quot(z, ERA_DAYS);
		doe    = z - era * ERA_DAYS;
		yoe    = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
		doy    = doe - (365 * yoe + yoe / 4 - yoe / 100);
		mp     = (5 * doy + 2) / 153;
		d      = doy - (153 * mp + 2) / 5 + 1;
		m      = (mp < 10) ? mp + 3 : mp - 9;
		y      = yoe + era * 400 + ((m <= 2) ? 1 : 0);
		if (y < YEAR_FIRST)
			r = '{12'd1901, 4'd1, 5'd1, 5'd0, 6'd0};
		else if (y > YEAR_LAST)
			r = '{12'd2242, 4'd12, 5'd31, 5'd23, 6'd59};
		else
			r = '{y[11:0], m[3:0], d[4:0], 5'(sod / HOUR_SECS), 6'((sod % HOUR_SECS) / MIN_SECS)};
		return r;
	endfunction

	task automatic check_field(input string name, input logic [11:0] want, input logic [11:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endtask

	// Compare each strobed result with the oldest predicted date
	always @(posedge clk) begin : check_results
		civil_t want;
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (expected_dates.size() == 0) begin
				$display("%0t: unexpected result %0d-%0d-%0d %0d:%0d, expected nothing",
					$time, year, month, day_of_month, hour, minute);
				errors++;
			end else begin
				want = expected_dates.pop_front();
				check_field("year", want.year, year);
				check_field("month", 12'(want.month), 12'(month));
				check_field("day_of_month", 12'(want.day), 12'(day_of_month));
				check_field("hour", 12'(want.hour), 12'(hour));
				check_field("minute", 12'(want.minute), 12'(minute));
				checked++;
			end
		end
	end

	// Issue one request, hold it until accepted, then optionally go idle
	task automatic send_seconds(input logic [31:0] secs, input int gap);
		start        <= 1'b1;
		boot_seconds <= secs;
		@(posedge clk);
		while (busy) @(posedge clk);
		expected_dates.push_back(to_civil(secs, offset_now));
		sent++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop start and wait until every pending date has come back
	task automatic drain();
		start <= 1'b0;
		while (expected_dates.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_offset(input logic [33:0] value);
		drain();
		cfg_valid            <= 1'b1;
		epoch_offset_seconds <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid  <= 1'b0;
		offset_now = value;
		offset_writes++;
	endtask

	// Idle cycles before the next request; each cycle is idle with chance idle_pct
	function automatic int pick_gap(input int idle_pct);
		int g;
		g = 0;
		while ($urandom_range(99, 0) < idle_pct)
			g++;
		return g;
	endfunction

	function automatic logic [33:0] pick_offset();
		longint v;
		case ($urandom_range(5, 0))
			0: v = longint'({$urandom_range(3, 0), $urandom()});
			1, 2: v = longint'($urandom()) * 2 + longint'($urandom_range(1, 0)) + OFS_LOW;
			3: v = OFS_LOW;
			4: v = OFS_MAX;
			default: v = UNIX_FIRST + longint'($urandom_range(86400 * 400, 0));
		endcase
		return v[33:0];
	endfunction

	// Mostly random seconds; some land near midnight or near a clipping edge
	function automatic logic [31:0] pick_seconds(input logic signed [33:0] offset);
		longint ofs, target, b;
		ofs = offset;
		case ($urandom_range(9, 0))
			6, 7: target = floor_quot(ofs + longint'($urandom()), DAY_SECS) * DAY_SECS
				+ longint'($urandom_range(120, 0)) - 60;
			8: target = UNIX_FIRST + longint'($urandom_range(400, 0)) - 200;
			9: target = UNIX_BEYOND + longint'($urandom_range(400, 0)) - 200;
			default: return $urandom();
		endcase
		b = target - ofs;
		if (b >= 0 && b <= 64'sd4294967295)
			return b[31:0];
		return $urandom();
	endfunction

	// Calendar points with the offset left at its reset value of zero
	task automatic test_reset_offset_calendar();
		send_seconds(32'd0, $urandom_range(1, 0));
		send_seconds(32'hFFFF_FFFF, $urandom_range(1, 0));
		send_seconds(32'd86399, $urandom_range(1, 0));
		send_seconds(32'd86400, $urandom_range(1, 0));
		send_seconds(32'd68169600, $urandom_range(1, 0));
		send_seconds(32'd951782400, $urandom_range(1, 0));
		send_seconds(32'd951868800, $urandom_range(1, 0));
		send_seconds(32'd4107542399, $urandom_range(1, 0));
		send_seconds(32'd946684799, $urandom_range(1, 0));
		send_seconds(32'd946684800, $urandom_range(1, 0));
	endtask

	// Unix time before 1970: floor division keeps the second of day positive
	task automatic test_negative_time();
		write_offset(OFS_LOW[33:0]);
		send_seconds(32'd0, $urandom_range(1, 0));
		send_seconds(32'd2147483647, $urandom_range(1, 0));
		send_seconds(32'd2147483648, $urandom_range(1, 0));
	endtask

	// Both ends of the year range, including offsets outside the stated range
	task automatic test_year_clipping();
		write_offset(OFS_MIN[33:0]);
		send_seconds(32'd0, $urandom_range(1, 0));
		send_seconds(32'hFFFF_FFFF, $urandom_range(1, 0));
		write_offset(34'(UNIX_FIRST - 60));
		send_seconds(32'd0, $urandom_range(1, 0));
		send_seconds(32'd60, $urandom_range(1, 0));
		send_seconds(32'd120, $urandom_range(1, 0));
		write_offset(OFS_MAX[33:0]);
		send_seconds(32'd0, $urandom_range(1, 0));
		send_seconds(32'd25095749, $urandom_range(1, 0));
		send_seconds(32'd25095808, $urandom_range(1, 0));
		send_seconds(32'd25095809, $urandom_range(1, 0));
		send_seconds(32'hFFFF_FFFF, $urandom_range(1, 0));
	endtask

	// Random requests, new offset every segment, idle gaps at idle_pct
	task automatic test_random_traffic(input int idle_pct, input int n_items);
		for (int i = 0; i < n_items; i++) begin
			if (i % 110 == 0)
				write_offset(pick_offset());
			send_seconds(pick_seconds(offset_now), pick_gap(idle_pct));
		end
	endtask

	initial begin
		arst_n               <= 1'b0;
		start                <= 1'b0;
		cfg_valid            <= 1'b0;
		boot_seconds         <= '0;
		epoch_offset_seconds <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_offset_calendar();
		test_negative_time();
		test_year_clipping();
		test_random_traffic(0, 550);
		test_random_traffic(60, 550);
		test_random_traffic(9, 500);
		drain();

		$display("Converted %0d timestamps, checked %0d dates across %0d offset settings",
			sent, checked, offset_writes);
		$display("Idle phases: none, sender 60 percent, sender 9 percent");
		if (errors == 0 && expected_dates.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches, %0d dates never returned", errors, expected_dates.size());
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/scdt_pkg.sv
hw/rtl/seconds_to_civil_datetime.sv
test/tb_top.sv
